[rtl/dsfd_pkg.sv]
// Package: symbols, token and result types, and the CRC-16 word step of the frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package dsfd_pkg;

    localparam logic [7:0]  SYM_DLE  = 8'h90;
    localparam logic [7:0]  SYM_STX  = 8'h02;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_GOOD = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_STX  = 3'd1,
        PH_OP   = 3'd2,
        PH_LEN  = 3'd3,
        PH_DATA = 3'd4,
        PH_CK1  = 3'd5,
        PH_CK2  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_OP   = 3'd1,
        K_LEN  = 3'd2,
        K_DATA = 3'd3,
        K_CK1  = 3'd4,
        K_CK2  = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [8:0] index;
    } t_tok;

    typedef struct packed {
        logic [1:0] status;
        logic       pv;
        logic [7:0] pb;
        logic [8:0] pi;
        logic [7:0] op;
        logic [7:0] words;
    } t_res;

    function automatic logic [15:0] crc_word(input logic [15:0] crc_in,
                                             input logic [15:0] word);
        logic [15:0] crc;
        logic        carry;
        crc = crc_in;
        for (int i = 15; i >= 0; i--) begin
            carry = (crc & CRC_TOP) != 16'h0;
            crc   = {crc[14:0], word[i]};
            if (carry) begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

[rtl/dle_stx_frame_decoder.sv]
// Top level of the DLE STX byte-stuffed frame decoder with CRC-16 check.
//
//  channel | direction | handshake         | fields
//  --------+-----------+-------------------+-------------------------------------------
//  input   | in        | push / full       | i_rx_byte
//  result  | out       | empty / pop       | o_frame_status, o_payload_valid,
//          |           |                   | o_payload_byte, o_payload_index,
//          |           |                   | o_frame_op, o_frame_words
//
//  One byte per cycle while full is low; every byte gives exactly one result.
//  A result reaches the ports through the token queue and then the result queue, both registered.
//  The front end classifies bytes, the back end runs a 16-bit CRC word step on the length token,
//  on every second payload byte and on the first check byte. Reset is synchronous and clears both
//  queues and the parse state. full rises when the two-entry token queue holds two requests; the back end stalls
//  while the two-entry result queue is full.
`timescale 1ns / 1ps
`default_nettype none

module dle_stx_frame_decoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic [7:0]    i_rx_byte,
    output logic               empty,
    input  wire logic          pop,
    output logic [1:0]         o_frame_status,
    output logic               o_payload_valid,
    output logic [7:0]         o_payload_byte,
    output logic [8:0]         o_payload_index,
    output logic [7:0]         o_frame_op,
    output logic [7:0]         o_frame_words
);

    dsfd_pkg::t_tok front_tok;
    dsfd_pkg::t_tok q_tok;
    dsfd_pkg::t_res res;
    logic           take;
    logic           q_valid;
    logic           q_pop;

    assign take = push && !full;

    dsfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_tok   (front_tok)
    );

    dsfd_tok_queue u_tok_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_tok   (front_tok),
        .o_full  (full),
        .o_valid (q_valid),
        .o_tok   (q_tok),
        .i_pop   (q_pop)
    );

    dsfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_tok       (q_tok),
        .o_tok_pop   (q_pop),
        .o_empty     (empty),
        .o_res       (res),
        .i_pop       (pop)
    );

    assign o_frame_status  = res.status;
    assign o_payload_valid = res.pv;
    assign o_payload_byte  = res.pb;
    assign o_payload_index = res.pi;
    assign o_frame_op      = res.op;
    assign o_frame_words   = res.words;

endmodule

`default_nettype wire

[rtl/dsfd_front.sv]
// Front end: unstuffing, frame phase tracking and byte classification into tokens.
`timescale 1ns / 1ps
`default_nettype none

module dsfd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_take,
    input  wire logic [7:0]    i_byte,
    output dsfd_pkg::t_tok     o_tok
);

    dsfd_pkg::t_phase r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [7:0]       r_words, n_words;
    logic [8:0]       r_pos, n_pos;
    logic [8:0]       pos_inc;
    logic             handled;

    assign pos_inc = r_pos + 9'd1;

    always_comb begin
        handled = 1'b1;
        if (r_esc && i_byte == dsfd_pkg::SYM_STX) begin
            handled = 1'b1;
        end else if (r_phase == dsfd_pkg::PH_HUNT && i_byte == dsfd_pkg::SYM_DLE) begin
            handled = 1'b1;
        end else if (i_byte == dsfd_pkg::SYM_DLE && !r_esc) begin
            handled = 1'b1;
        end else if (r_esc && i_byte != dsfd_pkg::SYM_DLE) begin
            handled = 1'b1;
        end else begin
            handled = 1'b0;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_esc   = r_esc;
        n_words = r_words;
        n_pos   = r_pos;
        if (r_esc && i_byte == dsfd_pkg::SYM_STX) begin
            n_phase = dsfd_pkg::PH_OP;
            n_esc   = 1'b0;
        end else if (r_phase == dsfd_pkg::PH_HUNT && i_byte == dsfd_pkg::SYM_DLE) begin
            n_phase = dsfd_pkg::PH_STX;
        end else if (i_byte == dsfd_pkg::SYM_DLE && !r_esc) begin
            n_esc = 1'b1;
        end else if (r_esc && i_byte != dsfd_pkg::SYM_DLE) begin
            n_esc   = 1'b0;
            n_phase = dsfd_pkg::PH_HUNT;
        end else begin
            n_esc = 1'b0;
            unique case (r_phase)
                dsfd_pkg::PH_STX: begin
                    n_phase = (i_byte == dsfd_pkg::SYM_STX) ? dsfd_pkg::PH_OP
                                                            : dsfd_pkg::PH_HUNT;
                end
                dsfd_pkg::PH_OP: begin
                    n_phase = dsfd_pkg::PH_LEN;
                end
                dsfd_pkg::PH_LEN: begin
                    n_words = i_byte;
                    n_pos   = 9'd0;
                    n_phase = (i_byte == 8'd0) ? dsfd_pkg::PH_CK1 : dsfd_pkg::PH_DATA;
                end
                dsfd_pkg::PH_DATA: begin
                    n_pos = pos_inc;
                    if ({1'b0, pos_inc} >= {1'b0, r_words, 1'b0}) begin
                        n_phase = dsfd_pkg::PH_CK1;
                    end
                end
                dsfd_pkg::PH_CK1: begin
                    n_phase = dsfd_pkg::PH_CK2;
                end
                default: begin
                    n_phase = dsfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        o_tok.kind  = dsfd_pkg::K_NONE;
        o_tok.data  = i_byte;
        o_tok.index = r_pos;
        if (!handled) begin
            unique case (r_phase)
                dsfd_pkg::PH_OP:   o_tok.kind = dsfd_pkg::K_OP;
                dsfd_pkg::PH_LEN:  o_tok.kind = dsfd_pkg::K_LEN;
                dsfd_pkg::PH_DATA: o_tok.kind = dsfd_pkg::K_DATA;
                dsfd_pkg::PH_CK1:  o_tok.kind = dsfd_pkg::K_CK1;
                dsfd_pkg::PH_CK2:  o_tok.kind = dsfd_pkg::K_CK2;
                default:           o_tok.kind = dsfd_pkg::K_NONE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dsfd_pkg::PH_HUNT;
            r_esc   <= 1'b0;
            r_words <= 8'd0;
            r_pos   <= 9'd0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
            r_words <= n_words;
            r_pos   <= n_pos;
        end
    end

    a_no_esc_in_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dsfd_pkg::PH_HUNT |-> !r_esc)
        else $error("escape pending while hunting");

    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == dsfd_pkg::PH_DATA |-> {1'b0, r_pos} < {1'b0, r_words, 1'b0})
        else $error("payload position past frame length");

    a_words_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dsfd_pkg::PH_DATA && $past(r_phase) == dsfd_pkg::PH_DATA)
        |-> $stable(r_words))
        else $error("frame length changed inside payload");

endmodule

`default_nettype wire

[rtl/dsfd_tok_queue.sv]
// Two-entry token queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module dsfd_tok_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  dsfd_pkg::t_tok     i_tok,
    output logic               o_full,
    output logic               o_valid,
    output dsfd_pkg::t_tok     o_tok,
    input  wire logic          i_pop
);

    dsfd_pkg::t_tok r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;
    logic           wr_en, rd_en;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_tok   = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr <= ~r_wr;
            end
            if (rd_en) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

`default_nettype wire

[rtl/dsfd_back.sv]
// Back end: opcode and length capture, CRC accumulation, check compare and result queue.
`timescale 1ns / 1ps
`default_nettype none

module dsfd_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tok_valid,
    input  dsfd_pkg::t_tok     i_tok,
    output logic               o_tok_pop,
    output logic               o_empty,
    output dsfd_pkg::t_res     o_res,
    input  wire logic          i_pop
);

    logic [7:0]     r_op, n_op;
    logic [7:0]     r_words, n_words;
    logic [7:0]     r_low, n_low;
    logic [7:0]     r_rxlo, n_rxlo;
    logic [15:0]    r_crc, n_crc;
    dsfd_pkg::t_res res;

    dsfd_pkg::t_res r_res_q [2];
    logic           r_res_wr, r_res_rd;
    logic [1:0]     r_res_cnt;
    logic           res_rd;

    assign o_tok_pop = i_tok_valid && r_res_cnt != 2'd2;
    assign o_empty   = r_res_cnt == 2'd0;
    assign o_res     = r_res_q[r_res_rd];
    assign res_rd    = i_pop && !o_empty;

    always_comb begin
        n_op       = r_op;
        n_words    = r_words;
        n_low      = r_low;
        n_rxlo     = r_rxlo;
        n_crc      = r_crc;
        res.status = dsfd_pkg::ST_BUSY;
        res.pv     = 1'b0;
        res.pb     = 8'd0;
        res.pi     = 9'd0;
        unique case (i_tok.kind)
            dsfd_pkg::K_OP: begin
                n_op = i_tok.data;
            end
            dsfd_pkg::K_LEN: begin
                n_words = i_tok.data;
                n_crc   = dsfd_pkg::crc_word(16'h0000, {i_tok.data, r_op});
            end
            dsfd_pkg::K_DATA: begin
                res.pv = 1'b1;
                res.pb = i_tok.data;
                res.pi = i_tok.index;
                if (i_tok.index[0]) begin
                    n_crc = dsfd_pkg::crc_word(r_crc, {i_tok.data, r_low});
                end else begin
                    n_low = i_tok.data;
                end
            end
            dsfd_pkg::K_CK1: begin
                n_rxlo = i_tok.data;
                n_crc  = dsfd_pkg::crc_word(r_crc, 16'h0000);
            end
            dsfd_pkg::K_CK2: begin
                res.status = ({i_tok.data, r_rxlo} == r_crc) ? dsfd_pkg::ST_GOOD
                                                             : dsfd_pkg::ST_BAD;
            end
            default: begin
            end
        endcase
        res.op    = n_op;
        res.words = n_words;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= 8'd0;
            r_words <= 8'd0;
            r_low   <= 8'd0;
            r_rxlo  <= 8'd0;
            r_crc   <= 16'h0000;
        end else if (o_tok_pop) begin
            r_op    <= n_op;
            r_words <= n_words;
            r_low   <= n_low;
            r_rxlo  <= n_rxlo;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_pop) begin
            r_res_q[r_res_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_wr  <= 1'b0;
            r_res_rd  <= 1'b0;
            r_res_cnt <= 2'd0;
        end else begin
            if (o_tok_pop) begin
                r_res_wr <= ~r_res_wr;
            end
            if (res_rd) begin
                r_res_rd <= ~r_res_rd;
            end
            r_res_cnt <= r_res_cnt + {1'b0, o_tok_pop} - {1'b0, res_rd};
        end
    end

    a_res_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt != 2'd3)
        else $error("result queue count out of range");

    a_status_not_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && res.status != dsfd_pkg::ST_BUSY) |-> !res.pv)
        else $error("frame status on a payload byte");

    a_exec_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok_pop && !res_rd) |=> !o_empty)
        else $error("executed token left no result");

endmodule

`default_nettype wire
